>>> hw/rtl/pbgra_pkg.sv
// Shared constants, register codes and the pixel job type for the premultiplied BGRA converter.
// No dependencies; every other file of the block imports this package.
package pbgra_pkg;

    // Size limits of the source image
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Register field widths
    localparam int DEPTH_W    = 3;
    localparam int SIZE_W     = 13;
    localparam int STRIDE_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE      = 2'd3;

    // Source depth codes
    localparam logic [DEPTH_W-1:0] DEPTH_GRAY       = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_GRAY_ALPHA = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_RGB        = 3'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_RGBA       = 3'd4;

    localparam logic [7:0] OPAQUE = 8'hff;

    // Job queue between the byte front end and the premultiply back end
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One completed pixel, colours not yet premultiplied
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       image_end;
    } pixel_job_t;

endpackage

>>> hw/rtl/pbgra_front.sv
// Front end: configuration registers, byte assembly, padding skip and row/column counters.
// Depends on pbgra_pkg; pushes one pixel_job_t into the job queue per completed pixel.
module pbgra_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pbgra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbgra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_source_byte,
    input  logic                             q_full,
    output logic                             q_push,
    output pbgra_pkg::pixel_job_t            q_data
);
    import pbgra_pkg::*;

    logic [DEPTH_W-1:0]  bpp_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [STRIDE_W-1:0] stride_reg;

    logic [1:0]          bp_reg;
    logic [7:0]          held_reg [0:2];
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [STRIDE_W-1:0] pad_reg;

    logic [DEPTH_W-1:0]  d_eff;
    logic [SIZE_W-1:0]   w_eff;
    logic [SIZE_W-1:0]   h_eff;
    logic [STRIDE_W-1:0] packed_len;
    logic [STRIDE_W-1:0] pad_load;
    logic                accept;
    logic                pad_busy;
    logic                collect;
    logic                complete;
    logic [DEPTH_W-1:0]  bp_inc;
    logic [SIZE_W-1:0]   col_inc;
    logic [SIZE_W-1:0]   row_inc;
    logic                row_done;
    logic                image_done;
    logic [7:0]          pix [0:3];

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= DEPTH_RGBA;
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
            stride_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_data[DEPTH_W-1:0];
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data[SIZE_W-1:0];
                REG_ROW_STRIDE:      stride_reg <= cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective depth and size with out-of-range values clamped
    always_comb begin
        if (bpp_reg == '0)
            d_eff = DEPTH_GRAY;
        else if (bpp_reg > DEPTH_RGBA)
            d_eff = DEPTH_RGBA;
        else
            d_eff = bpp_reg;

        if (width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // Packed row length and padding to skip at row end
    always_comb begin
        unique case (d_eff)
            DEPTH_GRAY:       packed_len = STRIDE_W'(w_eff);
            DEPTH_GRAY_ALPHA: packed_len = STRIDE_W'(w_eff) << 1;
            DEPTH_RGB:        packed_len = (STRIDE_W'(w_eff) << 1) + STRIDE_W'(w_eff);
            default:          packed_len = STRIDE_W'(w_eff) << 2;
        endcase
        if (stride_reg != '0 && stride_reg > packed_len)
            pad_load = stride_reg - packed_len;
        else
            pad_load = '0;
    end

    // Transaction classification
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign pad_busy = (pad_reg != '0);
    assign bp_inc   = DEPTH_W'(bp_reg) + DEPTH_W'(1);
    assign collect  = (bp_inc < d_eff);
    assign complete = accept && !pad_busy && !collect;

    assign col_inc    = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_inc    = SIZE_W'(row_reg) + SIZE_W'(1);
    assign row_done   = (col_inc >= w_eff);
    assign image_done = row_done && (row_inc >= h_eff);

    // Pixel bytes: held bytes with the current byte in the last slot
    always_comb begin
        for (int i = 0; i < 3; i++)
            pix[i] = held_reg[i];
        pix[3] = 8'h00;
        for (int i = 0; i < 4; i++) begin
            if (DEPTH_W'(i) == d_eff - DEPTH_W'(1))
                pix[i] = s_source_byte;
        end
    end

    // Channel mapping per depth
    always_comb begin
        unique case (d_eff)
            DEPTH_GRAY: begin
                q_data.red   = pix[0];
                q_data.green = pix[0];
                q_data.blue  = pix[0];
                q_data.alpha = OPAQUE;
            end
            DEPTH_GRAY_ALPHA: begin
                q_data.red   = pix[0];
                q_data.green = pix[0];
                q_data.blue  = pix[0];
                q_data.alpha = pix[1];
            end
            DEPTH_RGB: begin
                q_data.red   = pix[0];
                q_data.green = pix[1];
                q_data.blue  = pix[2];
                q_data.alpha = OPAQUE;
            end
            default: begin
                q_data.red   = pix[0];
                q_data.green = pix[1];
                q_data.blue  = pix[2];
                q_data.alpha = pix[3];
            end
        endcase
        q_data.row_end   = row_done;
        q_data.image_end = image_done;
    end

    assign q_push = complete;

    // Stream position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_reg  <= '0;
            col_reg <= '0;
            row_reg <= '0;
            pad_reg <= '0;
            for (int i = 0; i < 3; i++)
                held_reg[i] <= '0;
        end else if (accept) begin
            if (pad_busy) begin
                pad_reg <= pad_reg - STRIDE_W'(1);
            end else if (collect) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) == bp_reg)
                        held_reg[i] <= s_source_byte;
                end
                bp_reg <= bp_inc[1:0];
            end else begin
                bp_reg <= '0;
                for (int i = 0; i < 3; i++)
                    held_reg[i] <= '0;
                if (row_done) begin
                    col_reg <= '0;
                    pad_reg <= pad_load;
                    row_reg <= image_done ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    col_reg <= col_inc[COL_W-1:0];
                end
            end
        end
    end

endmodule

>>> hw/rtl/pbgra_fifo.sv
// Short job queue between the front end and the back end.
// Depends on pbgra_pkg for the job type and queue depth.
module pbgra_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  pbgra_pkg::pixel_job_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output pbgra_pkg::pixel_job_t pop_data
);
    import pbgra_pkg::*;

    pixel_job_t            mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + FIFO_PTR_W'(1);
        end
    end

endmodule

>>> hw/rtl/pbgra_back.sv
// Back end: premultiplies colour by alpha (multiply stage, then divide by 255 into the output register).
// Depends on pbgra_pkg for the job type.
module pbgra_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  pbgra_pkg::pixel_job_t q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_blue,
    output logic [7:0]            m_green,
    output logic [7:0]            m_red,
    output logic [7:0]            m_alpha,
    output logic                  m_row_end,
    output logic                  m_image_end
);
    import pbgra_pkg::*;

    // floor(x / 255) for x up to 255*255, by reciprocal with correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] sum;
        sum = x + 16'(x[15:8]) + 16'd1;
        return sum[15:8];
    endfunction

    logic        mul_valid_reg;
    logic [15:0] mul_red_reg;
    logic [15:0] mul_green_reg;
    logic [15:0] mul_blue_reg;
    logic [7:0]  mul_alpha_reg;
    logic        mul_row_end_reg;
    logic        mul_image_end_reg;
    logic        mul_ready;
    logic        out_ready;

    assign out_ready = !m_valid || m_ready;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign q_pop     = q_valid && mul_ready;

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mul_red_reg       <= 16'(q_data.red) * 16'(q_data.alpha);
            mul_green_reg     <= 16'(q_data.green) * 16'(q_data.alpha);
            mul_blue_reg      <= 16'(q_data.blue) * 16'(q_data.alpha);
            mul_alpha_reg     <= q_data.alpha;
            mul_row_end_reg   <= q_data.row_end;
            mul_image_end_reg <= q_data.image_end;
        end
    end

    // Divide stage into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_ready) begin
            m_valid <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && mul_valid_reg) begin
            m_red       <= div255(mul_red_reg);
            m_green     <= div255(mul_green_reg);
            m_blue      <= div255(mul_blue_reg);
            m_alpha     <= mul_alpha_reg;
            m_row_end   <= mul_row_end_reg;
            m_image_end <= mul_image_end_reg;
        end
    end

endmodule

>>> hw/rtl/pixel_to_premultiplied_bgra_core.sv
// Top level of the premultiplied BGRA pixel converter.
// Depends on pbgra_pkg, pbgra_front, pbgra_fifo and pbgra_back.

// Takes one source byte per cycle while the job queue has room, and emits one BGRA pixel each
// time the last byte of a pixel arrives; padding bytes and non-final pixel bytes are taken
// without a result. The edge that accepts a pixel's last byte writes its job into the two-entry
// job queue; the job then moves into the multiply stage and on into the divide-by-255
// output register. Input stalls only when that queue is full, which happens after the output
// has been held off. Configuration is written through the cfg_ channel (always ready) while
// no pixel is in flight; the user must keep to this, as the block does not enforce it. The
// stream counters are kept across writes and wrap at each image end. No clearing pass.
module pixel_to_premultiplied_bgra_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pbgra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbgra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_source_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_blue,
    output logic [7:0]                       m_green,
    output logic [7:0]                       m_red,
    output logic [7:0]                       m_alpha,
    output logic                             m_row_end,
    output logic                             m_image_end
);
    import pbgra_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    pixel_job_t q_in;
    pixel_job_t q_out;

    pbgra_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_byte (s_source_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    pbgra_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    pbgra_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_blue      (m_blue),
        .m_green     (m_green),
        .m_red       (m_red),
        .m_alpha     (m_alpha),
        .m_row_end   (m_row_end),
        .m_image_end (m_image_end)
    );

    // The last pixel of an image is always the last of its row
    a_image_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_end |-> m_row_end)
        else $error("image_end without row_end");

    // The front end never pushes a job into a full queue
    a_no_queue_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job queue overflow");

endmodule
